// ===== rtl/nrbd_pkg.sv =====
// Shared types, constants and helpers of the nibble rectangle blit decomposer.
package nrbd_pkg;

   // Field widths of the request and of one blit command
   localparam int X_W     = 10;
   localparam int Y_W     = 8;
   localparam int PEN_W   = 4;
   localparam int ADDR_W  = 19;
   localparam int WIDTH_W = 9;
   localparam int ROWS_W  = 8;
   localparam int VALUE_W = 8;
   localparam int PROD_W  = Y_W + WIDTH_W;

   // Configuration register widths and reset values
   localparam int                  PEN_MAP_W    = 64;
   localparam int                  CSR_INDEX_W  = 2;
   localparam logic [WIDTH_W-1:0]  STRIDE_RESET = 9'd320;

   // Default screen size
   localparam int SCREEN_WIDTH_DEF  = 640;
   localparam int SCREEN_HEIGHT_DEF = 240;

   // Command list depth
   localparam int MAX_CMDS  = 5;
   localparam int CMD_CNT_W = $clog2(MAX_CMDS + 1);
   localparam int CMD_IDX_W = $clog2(MAX_CMDS);

   // Nibble masks
   localparam logic [VALUE_W-1:0] MASK_HI  = 8'hF0;
   localparam logic [VALUE_W-1:0] MASK_LO  = 8'h0F;
   localparam logic [VALUE_W-1:0] MASK_ALL = 8'hFF;

   typedef enum logic [1:0] {
      OP_FILL = 2'd0,
      OP_AND  = 2'd1,
      OP_OR   = 2'd2,
      OP_XOR  = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PEN_MAP     = 2'd0,
      CSR_SCREEN_BASE = 2'd1,
      CSR_ROW_STRIDE  = 2'd2
   } csr_index_type;

   // One blit command without its row count
   typedef struct packed {
      op_type               op;
      logic [ADDR_W-1:0]    address;
      logic [WIDTH_W-1:0]   width_bytes;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

   // Rectangle after saturation, row multiply and pen lookup
   typedef struct packed {
      logic                 kind;
      logic                 empty;
      logic [X_W-1:0]       x1;
      logic [X_W-1:0]       x2;
      logic [PROD_W-1:0]    row_off;
      logic [ROWS_W-1:0]    rows;
      logic [PEN_W-1:0]     colour;
   } stage_type;

   // Full command list of one rectangle
   typedef struct packed {
      cmd_type [MAX_CMDS-1:0] cmds;
      logic [CMD_CNT_W-1:0]   count;
      logic [ROWS_W-1:0]      rows;
   } plan_type;

   function automatic cmd_type make_cmd(op_type op, logic [ADDR_W-1:0] address,
                                        logic [WIDTH_W-1:0] width_bytes,
                                        logic [VALUE_W-1:0] value);
      cmd_type c;
      c.op          = op;
      c.address     = address;
      c.width_bytes = width_bytes;
      c.value       = value;
      return c;
   endfunction

endpackage

// ===== rtl/nrbd_build.sv =====
// Command list builder: turns one prepared rectangle into up to five blit commands.
module nrbd_build
   import nrbd_pkg::*;
(
   input  stage_type          stage,
   input  logic [ADDR_W-1:0]  screen_base,
   output plan_type           plan
);

   logic [WIDTH_W-1:0]   bl;
   logic [WIDTH_W-1:0]   br;
   logic                 odd_l;
   logic                 even_r;
   logic [VALUE_W-1:0]   colour_byte;
   logic [ADDR_W-1:0]    row_addr;
   logic [ADDR_W-1:0]    addr_bl;
   logic [ADDR_W-1:0]    addr_br;
   logic [WIDTH_W:0]     bl_run;
   logic [WIDTH_W-1:0]   br_run;
   logic                 run_ok;
   logic [WIDTH_W-1:0]   run_width;
   logic [ADDR_W-1:0]    addr_run;

   // Byte columns, edge parity and addresses
   always_comb begin
      bl          = stage.x1[X_W-1:1];
      br          = stage.x2[X_W-1:1];
      odd_l       = stage.x1[0];
      even_r      = !stage.x2[0];
      colour_byte = {stage.colour, stage.colour};
      row_addr    = screen_base + ADDR_W'(stage.row_off);
      addr_bl     = row_addr + ADDR_W'(bl);
      addr_br     = row_addr + ADDR_W'(br);
      // run of whole bytes once partial edge bytes are peeled off
      bl_run      = {1'b0, bl} + (WIDTH_W+1)'(odd_l);
      br_run      = br - WIDTH_W'(even_r);
      run_ok      = {1'b0, br_run} >= bl_run;
      run_width   = br_run - bl_run[WIDTH_W-1:0] + WIDTH_W'(1);
      addr_run    = row_addr + ADDR_W'(bl_run[WIDTH_W-1:0]);
   end

   // Append commands in emission order
   always_comb begin
      logic [CMD_CNT_W-1:0] n;
      logic [VALUE_W-1:0]   xmask;
      n         = '0;
      xmask     = MASK_ALL;
      plan.cmds = '0;
      plan.rows = stage.rows;
      if (stage.empty) begin
         n = '0;
      end else if (!stage.kind) begin
         if (bl == br) begin
            if (!odd_l && !even_r) begin
               plan.cmds[0] = make_cmd(OP_FILL, addr_bl, WIDTH_W'(1), colour_byte);
               n = CMD_CNT_W'(1);
            end else if (odd_l) begin
               plan.cmds[0] = make_cmd(OP_AND, addr_bl, WIDTH_W'(1), MASK_HI);
               plan.cmds[1] = make_cmd(OP_OR, addr_bl, WIDTH_W'(1), colour_byte & MASK_LO);
               n = CMD_CNT_W'(2);
            end else begin
               plan.cmds[0] = make_cmd(OP_AND, addr_bl, WIDTH_W'(1), MASK_LO);
               plan.cmds[1] = make_cmd(OP_OR, addr_bl, WIDTH_W'(1), colour_byte & MASK_HI);
               n = CMD_CNT_W'(2);
            end
         end else begin
            if (odd_l) begin
               plan.cmds[n[CMD_IDX_W-1:0]] =
                  make_cmd(OP_AND, addr_bl, WIDTH_W'(1), MASK_HI);
               n = n + CMD_CNT_W'(1);
               plan.cmds[n[CMD_IDX_W-1:0]] =
                  make_cmd(OP_OR, addr_bl, WIDTH_W'(1), colour_byte & MASK_LO);
               n = n + CMD_CNT_W'(1);
            end
            if (even_r) begin
               plan.cmds[n[CMD_IDX_W-1:0]] =
                  make_cmd(OP_AND, addr_br, WIDTH_W'(1), MASK_LO);
               n = n + CMD_CNT_W'(1);
               plan.cmds[n[CMD_IDX_W-1:0]] =
                  make_cmd(OP_OR, addr_br, WIDTH_W'(1), colour_byte & MASK_HI);
               n = n + CMD_CNT_W'(1);
            end
            if (run_ok) begin
               plan.cmds[n[CMD_IDX_W-1:0]] =
                  make_cmd(OP_FILL, addr_run, run_width, colour_byte);
               n = n + CMD_CNT_W'(1);
            end
         end
      end else begin
         if (bl == br) begin
            if (odd_l) begin
               xmask = MASK_LO;
            end else if (even_r) begin
               xmask = MASK_HI;
            end
            plan.cmds[0] = make_cmd(OP_XOR, addr_bl, WIDTH_W'(1), xmask);
            n = CMD_CNT_W'(1);
         end else begin
            if (odd_l) begin
               plan.cmds[n[CMD_IDX_W-1:0]] = make_cmd(OP_XOR, addr_bl, WIDTH_W'(1), MASK_LO);
               n = n + CMD_CNT_W'(1);
            end
            if (even_r) begin
               plan.cmds[n[CMD_IDX_W-1:0]] = make_cmd(OP_XOR, addr_br, WIDTH_W'(1), MASK_HI);
               n = n + CMD_CNT_W'(1);
            end
            if (run_ok) begin
               plan.cmds[n[CMD_IDX_W-1:0]] = make_cmd(OP_XOR, addr_run, run_width, MASK_ALL);
               n = n + CMD_CNT_W'(1);
            end
         end
      end
      plan.count = n;
   end

endmodule

// ===== rtl/nrbd_emit.sv =====
// Command list holder and output register: sends one blit command per transfer.
module nrbd_emit
   import nrbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                plan_valid,
   input  plan_type            plan,
   output logic                plan_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,  // address, width_bytes, rows, value, 4 zero bits
   output logic [1:0]          rsp_tuser,  // op
   output logic                rsp_tlast
);

   logic                  list_valid_ff, list_valid_in;
   plan_type              list_ff, list_in;
   logic [CMD_IDX_W-1:0]  idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cmd_type               rsp_cmd_ff, rsp_cmd_in;
   logic [ROWS_W-1:0]     rsp_rows_ff, rsp_rows_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  take;
   logic                  is_final;
   logic                  load;

   // Advance the list one command per free output slot
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      take       = list_valid_ff && out_free;
      is_final   = CMD_CNT_W'(idx_ff) == list_ff.count - CMD_CNT_W'(1);
      plan_ready = !list_valid_ff || (take && is_final);
      load       = plan_valid && plan_ready && (plan.count != '0);

      list_valid_in = list_valid_ff;
      list_in       = list_ff;
      idx_in        = idx_ff;
      if (load) begin
         list_valid_in = 1'b1;
         list_in       = plan;
         idx_in        = '0;
      end else if (take && is_final) begin
         list_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + CMD_IDX_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_rows_in  = rsp_rows_ff;
      rsp_last_in  = rsp_last_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = list_ff.cmds[idx_ff];
         rsp_rows_in  = list_ff.rows;
         rsp_last_in  = is_final;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         list_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         list_valid_ff <= list_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      list_ff     <= list_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_rows_ff <= rsp_rows_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_cmd_ff.value, rsp_rows_ff, rsp_cmd_ff.width_bytes,
                        rsp_cmd_ff.address};
   assign rsp_tuser  = rsp_cmd_ff.op;
   assign rsp_tlast  = rsp_last_ff;

   // A held list always points at a command it owns
   assert property (@(posedge clock) disable iff (reset)
      list_valid_ff |-> (CMD_CNT_W'(idx_ff) < list_ff.count) &&
                        (list_ff.count <= CMD_CNT_W'(MAX_CMDS)))
      else $error("command index outside held list");

   // An AND mask is never the final command of a rectangle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_cmd_ff.op == OP_AND) |-> !rsp_last_ff)
      else $error("AND command marked last");

   // The OR that completes a nibble follows its AND straight away
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tready && (rsp_cmd_ff.op == OP_AND)
      |=> rsp_valid_ff && (rsp_cmd_ff.op == OP_OR))
      else $error("AND not followed by OR");

   // Only fill and XOR commands span more than one byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_cmd_ff.width_bytes != WIDTH_W'(1))
      |-> (rsp_cmd_ff.op == OP_FILL) || (rsp_cmd_ff.op == OP_XOR))
      else $error("partial-byte command wider than one byte");

endmodule

// ===== rtl/nibble_rect_blit_decomposer_top.sv =====
// Top level of the nibble rectangle blit decomposer: request stages and register file.
// A rectangle passes through the input stage, the prepared stage and the command list holder
// before its first command is registered on the output. Each rectangle yields 0 to 5 commands,
// and the single result channel sends one command per transfer.
// Reset clears all stages and sets pen_map and screen_base to 0, row_stride to 320.
module nibble_rect_blit_decomposer_top
   import nrbd_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [39:0]             req_tdata,  // left_x, top_y, right_x, bottom_y, pen
   input  logic                    req_tuser,  // kind
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,  // address, width_bytes, rows, value, 4 zero bits
   output logic [1:0]              rsp_tuser,  // op
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [PEN_MAP_W-1:0]    csr_wdata
);

   localparam int XMAX = SCREEN_WIDTH - 1;
   localparam int YMAX = SCREEN_HEIGHT - 1;

   // Configuration registers
   logic [PEN_MAP_W-1:0]  pen_map_ff;
   logic [ADDR_W-1:0]     screen_base_ff;
   logic [WIDTH_W-1:0]    row_stride_ff;

   // Input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_kind_ff;
   logic [X_W-1:0]        s1_left_x_ff;
   logic [Y_W-1:0]        s1_top_y_ff;
   logic [X_W-1:0]        s1_right_x_ff;
   logic [Y_W-1:0]        s1_bottom_y_ff;
   logic [PEN_W-1:0]      s1_pen_ff;

   // Prepared stage
   logic                  s2_valid_ff, s2_valid_in;
   stage_type             s2_ff, s2_in;

   logic                  s1_ready;
   logic                  s2_ready;
   logic                  req_take;
   logic                  s1_move;
   logic                  plan_ready;
   plan_type              plan;
   logic [X_W-1:0]        x1_sat;
   logic [X_W-1:0]        x2_sat;
   logic [Y_W-1:0]        y1_sat;
   logic [Y_W-1:0]        y2_sat;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_map_ff     <= '0;
         screen_base_ff <= '0;
         row_stride_ff  <= STRIDE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PEN_MAP:     pen_map_ff     <= csr_wdata;
            CSR_SCREEN_BASE: screen_base_ff <= csr_wdata[ADDR_W-1:0];
            CSR_ROW_STRIDE:  row_stride_ff  <= csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage handshakes
   always_comb begin
      s2_ready    = !s2_valid_ff || plan_ready;
      s1_ready    = !s1_valid_ff || s2_ready;
      req_tready  = s1_ready;
      req_take    = req_tvalid && s1_ready;
      s1_move     = s1_valid_ff && s2_ready;
      s1_valid_in = req_take || (s1_valid_ff && !s2_ready);
      s2_valid_in = s1_move || (s2_valid_ff && !plan_ready);
   end

   // Saturate to the screen, multiply the row and look up the pen
   always_comb begin
      x1_sat = (32'(s1_left_x_ff) > XMAX) ? X_W'(XMAX) : s1_left_x_ff;
      x2_sat = (32'(s1_right_x_ff) > XMAX) ? X_W'(XMAX) : s1_right_x_ff;
      y1_sat = (32'(s1_top_y_ff) > YMAX) ? Y_W'(YMAX) : s1_top_y_ff;
      y2_sat = (32'(s1_bottom_y_ff) > YMAX) ? Y_W'(YMAX) : s1_bottom_y_ff;

      s2_in.kind    = s1_kind_ff;
      s2_in.empty   = (x2_sat < x1_sat) || (y2_sat < y1_sat);
      s2_in.x1      = x1_sat;
      s2_in.x2      = x2_sat;
      s2_in.row_off = PROD_W'(y1_sat) * PROD_W'(row_stride_ff);
      s2_in.rows    = ROWS_W'(y2_sat - y1_sat + Y_W'(1));
      s2_in.colour  = pen_map_ff[{s1_pen_ff, 2'b00} +: PEN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Hold request fields and prepared rectangle
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff     <= req_tuser;
         s1_left_x_ff   <= req_tdata[9:0];
         s1_top_y_ff    <= req_tdata[17:10];
         s1_right_x_ff  <= req_tdata[27:18];
         s1_bottom_y_ff <= req_tdata[35:28];
         s1_pen_ff      <= req_tdata[39:36];
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
   end

   nrbd_build u_build (
      .stage       (s2_ff),
      .screen_base (screen_base_ff),
      .plan        (plan)
   );

   nrbd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .plan_valid (s2_valid_ff),
      .plan       (plan),
      .plan_ready (plan_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
